// ===== hdl/rls_pkg.sv =====
package rls_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int SEQ_BITS    = 16;
	localparam int MAX_RESULTS = 16;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

	localparam int LEN_W  = 19;
	localparam int ADDR_W = 48;
	localparam int HND_W  = 16;
	localparam int HDR_W  = 12;
	localparam int SEQ_W  = 16;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_GRANT   = 1'b1
	} opcode_t;

	typedef enum logic {
		CFG_HEADER_SIZE = 1'b0,
		CFG_OWN_ADDRESS = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_SEGMENT = 2'd0,
		STAT_NOTHING = 2'd1,
		STAT_ENQUEUED = 2'd2,
		STAT_FULL    = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_FLUSH
	} state_t;

	// one queue entry
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] dest;
		logic [HND_W-1:0]  handle;
	} entry_t;

	// one result beat
	typedef struct packed {
		stat_t             status;
		logic [SEQ_W-1:0]  seq_num;
		logic              start_flag;
		logic              end_flag;
		logic [LEN_W-1:0]  seg_length;
		logic [LEN_W-1:0]  pdu_offset;
		logic [HND_W-1:0]  seg_handle;
		logic [ADDR_W-1:0] dest_addr;
		logic              last;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic enqueue;
		logic grant_start;
		logic emit;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic can_emit;
		logic zero_seg;
	} dp_stat_t;

endpackage

// ===== hdl/radio_link_segmenter_core.sv =====
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   opcode pdu_length pdu_dest pdu_handle grant_size
// out      output     out_valid/out_stall status seq_num start_flag end_flag seg_length
//                                         pdu_offset seg_handle dest_addr last
// cfg      input      cfg_we              cfg_index cfg_data
//
// an enqueue is handled in the idle state; a grant passes through a read and an evaluate state
// for each segment, the read state being set by the registered read of the queue head
// one segment is held back a step so that its last flag is known before it leaves
// arst_n clears pointers, counts, sequence number and valid flags and sets the header size to 32;
// payload registers and queue contents are not cleared
// out_stall holds the result register; new beats are taken only while it can move
module radio_link_segmenter_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [rls_pkg::LEN_W-1:0]   pdu_length,
	input  logic [rls_pkg::ADDR_W-1:0]  pdu_dest,
	input  logic [rls_pkg::HND_W-1:0]   pdu_handle,
	input  logic [rls_pkg::LEN_W-1:0]   grant_size,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [rls_pkg::SEQ_W-1:0]   seq_num,
	output logic                        start_flag,
	output logic                        end_flag,
	output logic [rls_pkg::LEN_W-1:0]   seg_length,
	output logic [rls_pkg::LEN_W-1:0]   pdu_offset,
	output logic [rls_pkg::HND_W-1:0]   seg_handle,
	output logic [rls_pkg::ADDR_W-1:0]  dest_addr,
	output logic                        last,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [rls_pkg::ADDR_W-1:0]  cfg_data
);

	rls_pkg::cmd_t     cmd;
	rls_pkg::dp_stat_t st;
	rls_pkg::res_t     res;

	// sequencer
	rls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.st       (st),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// queue, segment arithmetic and result registers
	rls_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pdu_length (pdu_length),
		.pdu_dest   (pdu_dest),
		.pdu_handle (pdu_handle),
		.grant_size (grant_size),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.res        (res)
	);

	assign status     = res.status;
	assign seq_num    = res.seq_num;
	assign start_flag = res.start_flag;
	assign end_flag   = res.end_flag;
	assign seg_length = res.seg_length;
	assign pdu_offset = res.pdu_offset;
	assign seg_handle = res.seg_handle;
	assign dest_addr  = res.dest_addr;
	assign last       = res.last;

endmodule

// ===== hdl/rls_ctrl.sv =====
module rls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	input  rls_pkg::dp_stat_t st,
	output logic              in_stall,
	output rls_pkg::cmd_t     cmd
);

	rls_pkg::state_t state_q;
	rls_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rls_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			rls_pkg::ST_IDLE: begin
				in_stall = !st.out_free;
				if (in_valid && st.out_free) begin
					if (opcode == rls_pkg::OP_GRANT) begin
						cmd.grant_start = 1'b1;
						state_d         = rls_pkg::ST_READ;
					end else begin
						cmd.enqueue = 1'b1;
					end
				end
			end
			rls_pkg::ST_READ: begin
				state_d = rls_pkg::ST_EVAL;
			end
			rls_pkg::ST_EVAL: begin
				if (st.out_free) begin
					if (st.can_emit) begin
						cmd.emit = 1'b1;
						state_d  = st.zero_seg ? rls_pkg::ST_FLUSH : rls_pkg::ST_READ;
					end else begin
						cmd.finish = 1'b1;
						state_d    = rls_pkg::ST_IDLE;
					end
				end
			end
			rls_pkg::ST_FLUSH: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = rls_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rls_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/rls_datapath.sv =====
module rls_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rls_pkg::cmd_t               cmd,
	output rls_pkg::dp_stat_t           st,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [rls_pkg::ADDR_W-1:0]  cfg_data,
	input  logic [rls_pkg::LEN_W-1:0]   pdu_length,
	input  logic [rls_pkg::ADDR_W-1:0]  pdu_dest,
	input  logic [rls_pkg::HND_W-1:0]   pdu_handle,
	input  logic [rls_pkg::LEN_W-1:0]   grant_size,
	input  logic                        out_stall,
	output logic                        out_valid,
	output rls_pkg::res_t               res
);

	localparam logic [rls_pkg::PTR_W-1:0]  LAST_PTR = rls_pkg::PTR_W'(rls_pkg::QUEUE_DEPTH - 1);
	localparam logic [rls_pkg::FILL_W-1:0] FULL_CNT = rls_pkg::FILL_W'(rls_pkg::QUEUE_DEPTH);
	localparam logic [rls_pkg::CNT_W-1:0]  MAX_CNT  = rls_pkg::CNT_W'(rls_pkg::MAX_RESULTS);

	// configuration registers
	logic [rls_pkg::HDR_W-1:0]  header_size_q;
	logic [rls_pkg::ADDR_W-1:0] own_address_q;

	// queue memory and its registered read port
	rls_pkg::entry_t mem [rls_pkg::QUEUE_DEPTH];
	rls_pkg::entry_t rd_q;

	logic [rls_pkg::PTR_W-1:0]  head_q, tail_q;
	logic [rls_pkg::FILL_W-1:0] fill_q;
	logic [rls_pkg::LEN_W-1:0]  head_off_q;
	logic [rls_pkg::SEQ_BITS-1:0] seq_q;

	// grant working registers
	logic [rls_pkg::LEN_W-1:0]  size_q, used_q;
	logic [rls_pkg::CNT_W-1:0]  cnt_q;
	logic [rls_pkg::ADDR_W-1:0] first_dest_q;

	// pending segment and output register
	rls_pkg::res_t pend_q;
	logic          pend_v_q;
	rls_pkg::res_t out_q;
	logic          out_v_q;

	logic signed [rls_pkg::LEN_W+1:0] room;
	logic                             room_pos;
	logic [rls_pkg::LEN_W-1:0]        pdu_left;
	logic                             whole;
	logic [rls_pkg::LEN_W-1:0]        take;
	logic [rls_pkg::LEN_W:0]          used_sum;
	logic                             q_full;
	rls_pkg::res_t                    seg;
	rls_pkg::res_t                    done_res;
	rls_pkg::res_t                    enq_res;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_size_q <= rls_pkg::HDR_W'(32);
			own_address_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rls_pkg::CFG_HEADER_SIZE: header_size_q <= cfg_data[rls_pkg::HDR_W-1:0];
				rls_pkg::CFG_OWN_ADDRESS: own_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// queue memory
	always_ff @(posedge clk) begin
		if (cmd.enqueue && !q_full) begin
			mem[tail_q] <= '{len: pdu_length, dest: pdu_dest, handle: pdu_handle};
		end
		rd_q <= mem[head_q];
	end

	// segment arithmetic on the head entry
	always_comb begin
		room = $signed({2'b00, size_q}) - $signed({2'b00, used_q})
			- $signed({(rls_pkg::LEN_W + 2 - rls_pkg::HDR_W)'(0), header_size_q});
		room_pos = !room[rls_pkg::LEN_W+1] && (room != '0);
		pdu_left = (head_off_q > rd_q.len) ? '0 : rd_q.len - head_off_q;
		whole    = room[rls_pkg::LEN_W:0] >= {1'b0, pdu_left};
		take     = whole ? pdu_left : room[rls_pkg::LEN_W-1:0];
		used_sum = {1'b0, used_q} + {1'b0, take}
			+ {(rls_pkg::LEN_W + 1 - rls_pkg::HDR_W)'(0), header_size_q};
		q_full   = fill_q == FULL_CNT;

		seg            = '0;
		seg.status     = rls_pkg::STAT_SEGMENT;
		seg.seq_num    = rls_pkg::SEQ_W'(seq_q);
		seg.start_flag = head_off_q == '0;
		seg.end_flag   = whole;
		seg.seg_length = take;
		seg.pdu_offset = head_off_q;
		seg.seg_handle = rd_q.handle;
		seg.dest_addr  = rd_q.dest;

		// answer to an enqueue
		enq_res        = '0;
		enq_res.status = q_full ? rls_pkg::STAT_FULL : rls_pkg::STAT_ENQUEUED;
		enq_res.last   = 1'b1;

		// closing beat of a grant
		if (pend_v_q) begin
			done_res      = pend_q;
			done_res.last = 1'b1;
		end else begin
			done_res        = '0;
			done_res.status = rls_pkg::STAT_NOTHING;
			done_res.last   = 1'b1;
		end

		// status to the controller
		st.out_free = !out_v_q || !out_stall;
		st.can_emit = (fill_q != '0) && (cnt_q < MAX_CNT)
			&& ((cnt_q == '0) || (rd_q.dest == first_dest_q)) && room_pos;
		st.zero_seg = (header_size_q == '0) && (take == '0);
	end

	// queue pointers, offset, sequence number, counts and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			fill_q     <= '0;
			head_off_q <= '0;
			seq_q      <= '0;
			cnt_q      <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			// result valid: loaded by a new beat, dropped once taken
			if (cmd.enqueue || (cmd.emit && pend_v_q) || cmd.finish) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			if (cmd.enqueue) begin
				if (!q_full) begin
					tail_q <= (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.grant_start) begin
				cnt_q    <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
				cnt_q    <= cnt_q + 1'b1;
				seq_q    <= seq_q + 1'b1;
				if (whole) begin
					head_q     <= (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
					fill_q     <= fill_q - 1'b1;
					head_off_q <= '0;
				end else begin
					head_off_q <= head_off_q + take;
				end
			end
			if (cmd.finish) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.grant_start) begin
			size_q <= grant_size;
			used_q <= '0;
		end
		if (cmd.enqueue) begin
			out_q <= enq_res;
		end
		if (cmd.emit) begin
			if (pend_v_q) begin
				out_q <= pend_q;
			end
			pend_q <= seg;
			used_q <= used_sum[rls_pkg::LEN_W-1:0];
			if (cnt_q == '0) begin
				first_dest_q <= rd_q.dest;
			end
		end
		if (cmd.finish) begin
			out_q <= done_res;
		end
	end

	assign out_valid = out_v_q;
	assign res       = out_q;

endmodule
